### src/tdhb_pkg.sv
package tdhb_pkg;

    // field widths of the stream items
    localparam int DIST_W     = 20;
    localparam int WGT_W      = 10;
    localparam int ROW_W      = 5;
    localparam int COL_W      = 5;
    localparam int IN_DATA_W  = 40;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;
    localparam int STEP_W     = 16;
    localparam int SPAN_W     = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_DIST_ORIGIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_SPAN    = 2'd2;

    localparam logic [DIST_W-1:0] ORIGIN_RESET = 20'd10810;
    localparam logic [STEP_W-1:0] STEP_RESET   = 16'd100;
    localparam logic [SPAN_W-1:0] SPAN_RESET   = 16'd90;

    // transaction kinds
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int WEIGHT_ENTRIES = 25;
    localparam logic [WGT_W-1:0] WEIGHT_TABLE [WEIGHT_ENTRIES] = '{
        10'd250, 10'd281, 10'd312, 10'd344, 10'd375, 10'd406, 10'd438, 10'd469,
        10'd500, 10'd531, 10'd562, 10'd594, 10'd625, 10'd656, 10'd688, 10'd719,
        10'd750, 10'd781, 10'd812, 10'd844, 10'd875, 10'd906, 10'd938, 10'd969,
        10'd1000
    };

    typedef struct packed {
        logic done;
        logic found;
    } t_row_res;

    // {found, column}; table values are distinct so at most one entry matches
    function automatic logic [COL_W:0] weight_col(input logic [WGT_W-1:0] w);
        logic [COL_W:0] res;
        res = '0;
        for (int c = WEIGHT_ENTRIES - 1; c >= 0; c--) begin
            if (w == WEIGHT_TABLE[c]) begin
                res = {1'b1, COL_W'(c)};
            end
        end
        return res;
    endfunction

endpackage

### src/tdhb_mem.sv
module tdhb_mem #(
    parameter int DEPTH  = 550,
    parameter int DATA_W = 24,
    parameter int ADDR_W = 10
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/tdhb_row.sv
module tdhb_row #(
    parameter int NUM_ROWS = 22,
    parameter int IDX_W    = 5
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [tdhb_pkg::DIST_W-1:0]    i_dist,
    input  logic [tdhb_pkg::DIST_W-1:0]    i_origin,
    input  logic [tdhb_pkg::STEP_W-1:0]    i_step,
    input  logic [tdhb_pkg::SPAN_W-1:0]    i_span,
    output tdhb_pkg::t_row_res             o_res,
    output logic [IDX_W-1:0]               o_row
);
    import tdhb_pkg::*;

    localparam int ROW_BITS = 16 + $clog2(NUM_ROWS + 1);
    // holds the upper edge of the last row without wrap
    localparam int LO_W = ((ROW_BITS > DIST_W) ? ROW_BITS : DIST_W) + 1;

    logic              r_busy;
    logic [LO_W-1:0]   r_lo;
    logic [IDX_W-1:0]  r_idx;
    logic [DIST_W-1:0] r_dist;

    logic [LO_W-1:0]   hi;
    logic [LO_W-1:0]   dist_ext;
    logic              in_row;
    logic              stop;

    assign hi       = r_lo + LO_W'(i_span);
    assign dist_ext = LO_W'(r_dist);
    assign in_row   = (dist_ext >= r_lo) && (dist_ext <= hi);
    // lower edges never decrease, so once the sample lies below one no later row matches
    assign stop     = in_row || (dist_ext < r_lo) || (r_idx == IDX_W'(NUM_ROWS - 1));

    assign o_res.done  = r_busy && stop;
    assign o_res.found = in_row;
    assign o_row       = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && stop) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo   <= LO_W'(i_origin);
            r_idx  <= '0;
            r_dist <= i_dist;
        end else if (r_busy && !stop) begin
            r_lo  <= r_lo + LO_W'(i_step);
            r_idx <= r_idx + 1'b1;
        end
    end

endmodule

### src/two_d_histogram_binner.sv
// channel     direction  payload
// s_axis_*    in         tuser: func; tdata: dist_req, weight, read_row, read_col
// m_axis_*    out        tuser: hit; tdata: bin_row, bin_col, count
// i_cfg_*     in         register write: dist_origin, row_step, row_span
//
// a read transaction goes straight to the counter read; an add transaction first runs a row
// search that walks one row per cycle and stops after k rows (1 <= k <= NUM_ROWS)
// the counters sit in one memory with a registered read port: read, then increment and
// write back in the cycle the result is loaded into the output register
// after reset a clearing pass zeroes the NUM_ROWS*NUM_COLS counters, one per cycle, first
// a finished result waits in the output register; a new transaction is taken meanwhile
module two_d_histogram_binner #(
    parameter int NUM_ROWS    = 22,
    parameter int NUM_COLS    = 25,
    parameter int COUNT_WIDTH = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // dist_req, weight, read_row, read_col
    input  logic [tdhb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // func
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // bin_row, bin_col, count, zero padding
    output logic [((tdhb_pkg::ROW_W + tdhb_pkg::COL_W + COUNT_WIDTH + 7) / 8) * 8 - 1:0]
                                                m_axis_tdata,
    // hit
    output logic                                m_axis_tuser,
    input  logic                                i_cfg_wr_en,
    input  logic [tdhb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [tdhb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import tdhb_pkg::*;

    localparam int OUT_W  = ((ROW_W + COL_W + COUNT_WIDTH + 7) / 8) * 8;
    localparam int DEPTH  = NUM_ROWS * NUM_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;

    localparam logic [1:0] ST_CLEAR  = 2'd0;
    localparam logic [1:0] ST_IDLE   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_RMW    = 2'd3;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    // configuration
    logic [DIST_W-1:0] r_dist_origin;
    logic [STEP_W-1:0] r_row_step;
    logic [SPAN_W-1:0] r_row_span;

    // control
    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic              r_out_valid, n_out_valid;

    // transaction context
    logic              r_func, n_func;
    logic              r_hit, n_hit;
    logic              r_rd_ok, n_rd_ok;
    logic [ROW_W-1:0]  r_row_out, n_row_out;
    logic [COL_W-1:0]  r_col_out, n_col_out;
    logic [ADDR_W-1:0] r_addr, n_addr;
    logic [COL_W-1:0]  r_col, n_col;
    logic              r_col_ok, n_col_ok;

    // output payload
    logic                   r_out_hit, n_out_hit;
    logic [ROW_W-1:0]       r_out_row, n_out_row;
    logic [COL_W-1:0]       r_out_col, n_out_col;
    logic [COUNT_WIDTH-1:0] r_out_count, n_out_count;
    logic                   out_load;

    // input fields
    logic [DIST_W-1:0] in_dist;
    logic [WGT_W-1:0]  in_weight;
    logic [ROW_W-1:0]  in_row;
    logic [COL_W-1:0]  in_col;
    logic              in_accept;
    logic [COL_W:0]    col_match;

    // memory port
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [COUNT_WIDTH-1:0] mem_wdata;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;
    logic [COUNT_WIDTH-1:0] mem_rdata;
    logic [COUNT_WIDTH-1:0] cnt_inc;

    // row search
    logic       search_start;
    t_row_res   row_res;
    logic [IDX_W-1:0] row_idx;

    assign in_dist   = s_axis_tdata[DIST_W-1:0];
    assign in_weight = s_axis_tdata[DIST_W+WGT_W-1:DIST_W];
    assign in_row    = s_axis_tdata[DIST_W+WGT_W+ROW_W-1:DIST_W+WGT_W];
    assign in_col    = s_axis_tdata[DIST_W+WGT_W+ROW_W+COL_W-1:DIST_W+WGT_W+ROW_W];

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign col_match     = weight_col(in_weight);
    assign search_start  = in_accept && (s_axis_tuser == FUNC_ADD);
    assign cnt_inc       = (mem_rdata == COUNT_MAX) ? mem_rdata : mem_rdata + 1'b1;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_hit;
    assign m_axis_tdata  = OUT_W'({r_out_count, r_out_col, r_out_row});

    tdhb_row #(
        .NUM_ROWS (NUM_ROWS),
        .IDX_W    (IDX_W)
    ) u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (search_start),
        .i_dist   (in_dist),
        .i_origin (r_dist_origin),
        .i_step   (r_row_step),
        .i_span   (r_row_span),
        .o_res    (row_res),
        .o_row    (row_idx)
    );

    tdhb_mem #(
        .DEPTH  (DEPTH),
        .DATA_W (COUNT_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_func      = r_func;
        n_hit       = r_hit;
        n_rd_ok     = r_rd_ok;
        n_row_out   = r_row_out;
        n_col_out   = r_col_out;
        n_addr      = r_addr;
        n_col       = r_col;
        n_col_ok    = r_col_ok;
        n_out_hit   = r_out_hit;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        n_out_count = r_out_count;
        out_load    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_addr;
        mem_wdata   = cnt_inc;
        mem_re      = 1'b0;
        mem_raddr   = r_addr;

        unique case (r_state)
            ST_CLEAR: begin
                mem_we     = 1'b1;
                mem_waddr  = r_clr_addr;
                mem_wdata  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_accept) begin
                    n_func   = s_axis_tuser;
                    n_col    = col_match[COL_W-1:0];
                    n_col_ok = col_match[COL_W] && (int'(col_match[COL_W-1:0]) < NUM_COLS);
                    if (s_axis_tuser == FUNC_READ) begin
                        n_rd_ok   = (int'(in_row) < NUM_ROWS) && (int'(in_col) < NUM_COLS);
                        n_row_out = in_row;
                        n_col_out = in_col;
                        n_hit     = 1'b0;
                        mem_re    = 1'b1;
                        mem_raddr = ADDR_W'(in_row) * ADDR_W'(NUM_COLS) + ADDR_W'(in_col);
                        n_state   = ST_RMW;
                    end else begin
                        n_state = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (row_res.done) begin
                    n_hit   = row_res.found && r_col_ok;
                    n_addr  = ADDR_W'(row_idx) * ADDR_W'(NUM_COLS) + ADDR_W'(r_col);
                    n_state = ST_RMW;
                    if (row_res.found && r_col_ok) begin
                        mem_re    = 1'b1;
                        mem_raddr = n_addr;
                        n_row_out = ROW_W'(row_idx);
                        n_col_out = r_col;
                    end else begin
                        n_row_out = '0;
                        n_col_out = '0;
                    end
                end
            end
            ST_RMW: begin
                // counter data is held in the read register until the output slot frees
                if (!r_out_valid || m_axis_tready) begin
                    out_load  = 1'b1;
                    n_out_row = r_row_out;
                    n_out_col = r_col_out;
                    n_out_hit = r_hit;
                    if (r_func == FUNC_READ) begin
                        n_out_count = r_rd_ok ? mem_rdata : '0;
                    end else if (r_hit) begin
                        mem_we      = 1'b1;
                        n_out_count = cnt_inc;
                    end else begin
                        n_out_count = '0;
                    end
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist_origin <= ORIGIN_RESET;
            r_row_step    <= STEP_RESET;
            r_row_span    <= SPAN_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_DIST_ORIGIN: r_dist_origin <= i_cfg_data;
                CFG_ROW_STEP:    r_row_step    <= i_cfg_data[STEP_W-1:0];
                CFG_ROW_SPAN:    r_row_span    <= i_cfg_data[SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_hit     <= n_hit;
        r_rd_ok   <= n_rd_ok;
        r_row_out <= n_row_out;
        r_col_out <= n_col_out;
        r_addr    <= n_addr;
        r_col     <= n_col;
        r_col_ok  <= n_col_ok;
        if (out_load) begin
            r_out_hit   <= n_out_hit;
            r_out_row   <= n_out_row;
            r_out_col   <= n_out_col;
            r_out_count <= n_out_count;
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import tdhb_pkg::*;

    localparam int NUM_ROWS    = 22;
    localparam int NUM_COLS    = 25;
    localparam int COUNT_WIDTH = 24;
    localparam int M_DATA_W    = ((ROW_W + COL_W + COUNT_WIDTH + 7) / 8) * 8;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam int NUM_PHASES      = 7;
    localparam int NUM_MODES       = 4;
    localparam int ITEMS_PER_CHUNK = 50;
    localparam int DRAIN_CYCLES    = 30;

    // no idling, sender idle, receiver stalling, both
    localparam int SEND_IDLE_PCT [NUM_MODES] = '{0, 51, 0, 17};
    localparam int RECV_STALL_PCT [NUM_MODES] = '{0, 0, 51, 17};

    // phase 0 keeps the reset values, phase 4 is drawn at random
    localparam int PHASE_ORIGIN [NUM_PHASES] = '{10810, 0, 1048575, 1000, 0, 0, 10810};
    localparam int PHASE_STEP [NUM_PHASES]   = '{100, 1, 65535, 0, 0, 65535, 100};
    localparam int PHASE_SPAN [NUM_PHASES]   = '{90, 0, 65535, 500, 0, 65535, 90};
    localparam int RANDOM_PHASE = 4;

    typedef struct packed {
        logic              func;
        logic [DIST_W-1:0] dist_req;
        logic [WGT_W-1:0]  weight;
        logic [ROW_W-1:0]  rrow;
        logic [COL_W-1:0]  rcol;
    } t_sample;

    typedef struct packed {
        logic                   hit;
        logic [ROW_W-1:0]       row;
        logic [COL_W-1:0]       col;
        logic [COUNT_WIDTH-1:0] count;
    } t_bin_result;

    typedef struct packed {
        t_sample     s;
        logic        typed;
        t_bin_result want;
    } t_directed_row;

    localparam logic PREDICTED = 1'b0;
    localparam logic TYPED     = 1'b1;

    // reset geometry: row r spans 10810 + 100*r ... 10900 + 100*r
    // columns: func, dist_req, weight, read_row, read_col, typed, hit, row, col, count
    localparam int NUM_DIRECTED = 25;
    localparam t_directed_row DIRECTED_ROWS [NUM_DIRECTED] = '{
        {FUNC_READ, 20'd0,       10'd0,    5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        {FUNC_READ, 20'd0,       10'd0,    5'd31, 5'd31, TYPED, 1'b0, 5'd31, 5'd31, 24'd0},
        {FUNC_ADD,  20'd10810,   10'd250,  5'd0,  5'd0,  TYPED, 1'b1, 5'd0,  5'd0,  24'd1},
        {FUNC_ADD,  20'd10810,   10'd250,  5'd31, 5'd31, TYPED, 1'b1, 5'd0,  5'd0,  24'd2},
        {FUNC_ADD,  20'd10900,   10'd1000, 5'd0,  5'd0,  TYPED, 1'b1, 5'd0,  5'd24, 24'd1},
        {FUNC_ADD,  20'd10901,   10'd1000, 5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        {FUNC_ADD,  20'd10909,   10'd500,  5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        {FUNC_ADD,  20'd10910,   10'd281,  5'd0,  5'd0,  TYPED, 1'b1, 5'd1,  5'd1,  24'd1},
        {FUNC_ADD,  20'd13000,   10'd500,  5'd0,  5'd0,  TYPED, 1'b1, 5'd21, 5'd8,  24'd1},
        {FUNC_ADD,  20'd13001,   10'd500,  5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        // where a row past the last one would start
        {FUNC_ADD,  20'd13010,   10'd500,  5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        {FUNC_ADD,  20'd10809,   10'd250,  5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        {FUNC_ADD,  20'd0,       10'd0,    5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        {FUNC_ADD,  20'hFFFFF,   10'h3FF,  5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        {FUNC_ADD,  20'd10850,   10'd251,  5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd0},
        {FUNC_ADD,  20'd11500,   10'd969,  5'd0,  5'd0,  TYPED, 1'b1, 5'd6,  5'd23, 24'd1},
        {FUNC_ADD,  20'd12345,   10'd688,  5'd0,  5'd0,  PREDICTED, 1'b0, 5'd0, 5'd0, 24'd0},
        {FUNC_ADD,  20'hAAAAA,   10'h155,  5'd21, 5'd10, PREDICTED, 1'b0, 5'd0, 5'd0, 24'd0},
        {FUNC_ADD,  20'h55555,   10'h2AA,  5'd10, 5'd21, PREDICTED, 1'b0, 5'd0, 5'd0, 24'd0},
        {FUNC_READ, 20'hFFFFF,   10'h3FF,  5'd0,  5'd0,  TYPED, 1'b0, 5'd0,  5'd0,  24'd2},
        {FUNC_READ, 20'd0,       10'd0,    5'd21, 5'd8,  TYPED, 1'b0, 5'd21, 5'd8,  24'd1},
        {FUNC_READ, 20'd0,       10'd0,    5'd22, 5'd0,  TYPED, 1'b0, 5'd22, 5'd0,  24'd0},
        {FUNC_READ, 20'd0,       10'd0,    5'd0,  5'd25, TYPED, 1'b0, 5'd0,  5'd25, 24'd0},
        {FUNC_READ, 20'd0,       10'd0,    5'd6,  5'd23, TYPED, 1'b0, 5'd6,  5'd23, 24'd1},
        {FUNC_READ, 20'd0,       10'd0,    5'd15, 5'd14, PREDICTED, 1'b0, 5'd0, 5'd0, 24'd0}
    };

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // predictor state
    logic [DIST_W-1:0]      cur_origin = ORIGIN_RESET;
    logic [STEP_W-1:0]      cur_step   = STEP_RESET;
    logic [SPAN_W-1:0]      cur_span   = SPAN_RESET;
    logic [COUNT_WIDTH-1:0] bin_counts [NUM_ROWS*NUM_COLS];

    t_bin_result pending_bins [$];
    t_bin_result got_bin;
    t_bin_result want_bin;
    int          mismatches     = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;

    two_d_histogram_binner #(
        .NUM_ROWS    (NUM_ROWS),
        .NUM_COLS    (NUM_COLS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAIL");
        $finish;
    end

    // bins a sample or reads a counter, updating the histogram copy
    function automatic t_bin_result bin_sample(input t_sample s);
        t_bin_result      res;
        logic             row_found;
        logic             col_found;
        int               row_idx;
        int               col_idx;
        longint unsigned  lo;
        longint unsigned  hi;
        int               addr;
        res       = '0;
        row_found = 1'b0;
        col_found = 1'b0;
        row_idx   = 0;
        col_idx   = 0;
        if (s.func == FUNC_READ) begin
            res.row = s.rrow;
            res.col = s.rcol;
            if (s.rrow < NUM_ROWS && s.rcol < NUM_COLS) begin
                res.count = bin_counts[s.rrow * NUM_COLS + s.rcol];
            end
            return res;
        end
        for (int r = 0; r < NUM_ROWS; r++) begin
            // edges kept wide so that rows past the distance range never match
            lo = 64'(cur_origin) + 64'(r) * 64'(cur_step);
            hi = lo + 64'(cur_span);
            if (!row_found && 64'(s.dist_req) >= lo && 64'(s.dist_req) <= hi) begin
                row_found = 1'b1;
                row_idx   = r;
            end
        end
        for (int c = 0; c < NUM_COLS && c < WEIGHT_ENTRIES; c++) begin
            if (!col_found && s.weight == WEIGHT_TABLE[c]) begin
                col_found = 1'b1;
                col_idx   = c;
            end
        end
        if (row_found && col_found) begin
            addr = row_idx * NUM_COLS + col_idx;
            if (bin_counts[addr] != COUNT_MAX) begin
                bin_counts[addr] = bin_counts[addr] + 1'b1;
            end
            res.hit   = 1'b1;
            res.row   = ROW_W'(row_idx);
            res.col   = COL_W'(col_idx);
            res.count = bin_counts[addr];
        end
        return res;
    endfunction

    // mostly distances around row edges and weights from the table
    function automatic t_sample random_sample();
        t_sample         s;
        int              r;
        int              idx;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned d;
        s.func     = ($urandom_range(99) < 20) ? FUNC_READ : FUNC_ADD;
        s.dist_req = DIST_W'($urandom);
        s.weight   = WGT_W'($urandom);
        s.rrow     = ROW_W'($urandom);
        s.rcol     = COL_W'($urandom);
        if (s.func == FUNC_READ) begin
            if ($urandom_range(99) < 85) begin
                s.rrow = ROW_W'($urandom_range(NUM_ROWS - 1));
                s.rcol = COL_W'($urandom_range(NUM_COLS - 1));
            end
            return s;
        end
        if ($urandom_range(99) < 75) begin
            r  = $urandom_range(NUM_ROWS + 1);
            lo = 64'(cur_origin) + 64'(r) * 64'(cur_step);
            hi = lo + 64'(cur_span);
            case ($urandom_range(4))
                0: d = lo;
                1: d = hi;
                2: d = lo + 64'($urandom_range(cur_span));
                3: d = lo - 1;
                default: d = hi + 1;
            endcase
            if (d <= 64'hFFFFF) begin
                s.dist_req = DIST_W'(d);
            end
        end
        idx = $urandom_range(WEIGHT_ENTRIES - 1);
        case ($urandom_range(9))
            0, 1: s.weight = WGT_W'($urandom);
            2:    s.weight = WEIGHT_TABLE[idx] + 1'b1;
            3:    s.weight = WEIGHT_TABLE[idx] - 1'b1;
            default: s.weight = WEIGHT_TABLE[idx];
        endcase
        return s;
    endfunction

    // called and returns at a falling edge
    task automatic push_sample(input t_sample s, input logic typed, input t_bin_result want);
        t_bin_result res;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {s.rcol, s.rrow, s.weight, s.dist_req};
        s_axis_tuser  <= s.func;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        res = bin_sample(s);
        pending_bins.push_back(typed ? want : res);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending_bins.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_config(input logic [DIST_W-1:0] origin,
                                input logic [STEP_W-1:0] step,
                                input logic [SPAN_W-1:0] span);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx   <= CFG_DIST_ORIGIN;
        i_cfg_data  <= origin;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_ROW_STEP;
        i_cfg_data  <= CFG_DATA_W'(step);
        @(negedge i_clk);
        i_cfg_idx   <= CFG_ROW_SPAN;
        i_cfg_data  <= CFG_DATA_W'(span);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cur_origin = origin;
        cur_step   = step;
        cur_span   = span;
    endtask

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_bin.hit   = m_axis_tuser;
            got_bin.row   = m_axis_tdata[ROW_W-1:0];
            got_bin.col   = m_axis_tdata[ROW_W +: COL_W];
            got_bin.count = m_axis_tdata[ROW_W + COL_W +: COUNT_WIDTH];
            if (pending_bins.size() == 0) begin
                $display("%0t: unexpected transaction, expected none, got hit %0d row %0d col %0d count %0d",
                         $time, got_bin.hit, got_bin.row, got_bin.col, got_bin.count);
                mismatches++;
            end else begin
                want_bin = pending_bins.pop_front();
                if (got_bin.hit !== want_bin.hit) begin
                    $display("%0t: hit expected %0d got %0d", $time, want_bin.hit, got_bin.hit);
                    mismatches++;
                end
                if (got_bin.row !== want_bin.row) begin
                    $display("%0t: bin_row expected %0d got %0d", $time, want_bin.row, got_bin.row);
                    mismatches++;
                end
                if (got_bin.col !== want_bin.col) begin
                    $display("%0t: bin_col expected %0d got %0d", $time, want_bin.col, got_bin.col);
                    mismatches++;
                end
                if (got_bin.count !== want_bin.count) begin
                    $display("%0t: count expected %0d got %0d",
                             $time, want_bin.count, got_bin.count);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        foreach (bin_counts[i]) bin_counts[i] = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // the clearing pass after reset holds tready low, the handshake absorbs it
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            push_sample(DIRECTED_ROWS[i].s, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        end
        drain_results();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == RANDOM_PHASE) begin
                write_config(DIST_W'($urandom_range(900000)), STEP_W'($urandom_range(1, 3000)),
                             SPAN_W'($urandom_range(4000)));
            end else if (p != 0) begin
                write_config(DIST_W'(PHASE_ORIGIN[p]), STEP_W'(PHASE_STEP[p]),
                             SPAN_W'(PHASE_SPAN[p]));
            end
            for (int m = 0; m < NUM_MODES; m++) begin
                send_idle_pct  = SEND_IDLE_PCT[m];
                recv_stall_pct = RECV_STALL_PCT[m];
                repeat (ITEMS_PER_CHUNK) push_sample(random_sample(), PREDICTED, '0);
                // sender holds off until the histogram has answered everything
                drain_results();
            end
        end

        recv_stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_bins.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### sim.f
src/tdhb_pkg.sv
src/tdhb_mem.sv
src/tdhb_row.sv
src/two_d_histogram_binner.sv
dv/testbench.sv
